// ----- rtl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit bin allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int FFBA_NUM_BINS   = 16;
  localparam int FFBA_VALUE_BITS = 16;

  // fixed widths of the port fields
  localparam int OP_W    = 2;
  localparam int IDX_W   = 4;
  localparam int FIELD_W = 16;
  localparam int CNT_W   = 5;
  localparam int COST_W  = 20;

  localparam logic [CNT_W-1:0] BINS_IN_USE_RST = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_PLACE = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // control half of a request word walking down the cell row
  typedef struct packed {
    logic valid;
    op_t  op;
    logic found;  // some earlier cell took the item
    logic inc;    // a bin became non-empty
    logic dec;    // a non-empty bin was reloaded
  } tok_ctl_t;

endpackage

// ----- rtl/ffba_cell.sv -----
// ----------------------------------------------------------------------------
// ffba_cell
// One bin: capacity, cost, usage and non-empty mark. Applies a passing
// request word to its bin and hands the word to the next cell.
// ----------------------------------------------------------------------------
module ffba_cell
  import ffba_pkg::*;
#(
  parameter int VALUE_BITS = FFBA_VALUE_BITS,
  parameter int BIN_W      = 4,
  parameter int CELL_ID    = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv_i,
  input  logic [CNT_W-1:0]      bins_in_use_i,
  input  tok_ctl_t              ctl_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  logic [VALUE_BITS-1:0] cap_i,
  input  logic [VALUE_BITS-1:0] cost_i,
  input  logic [VALUE_BITS-1:0] size_i,
  input  logic [BIN_W-1:0]      chosen_i,
  input  logic [VALUE_BITS-1:0] cused_i,
  input  logic [VALUE_BITS-1:0] dcost_i,
  output tok_ctl_t              ctl_o,
  output logic [IDX_W-1:0]      idx_o,
  output logic [VALUE_BITS-1:0] cap_o,
  output logic [VALUE_BITS-1:0] cost_o,
  output logic [VALUE_BITS-1:0] size_o,
  output logic [BIN_W-1:0]      chosen_o,
  output logic [VALUE_BITS-1:0] cused_o,
  output logic [VALUE_BITS-1:0] dcost_o
);

  tok_ctl_t              ctl_r, ctl_nxt;
  logic [IDX_W-1:0]      idx_r;
  logic [VALUE_BITS-1:0] tcap_r, tcost_r, size_r, cused_r, cused_nxt, dcost_r, dcost_nxt;
  logic [BIN_W-1:0]      chosen_r, chosen_nxt;

  logic [VALUE_BITS-1:0] cap_r, cap_nxt, cost_r, cost_nxt, used_r, used_nxt;
  logic                  mark_r, mark_nxt;

  logic [VALUE_BITS:0]   sum;
  logic                  fits, hit_idx, in_range;

  always_comb begin
    ctl_nxt    = ctl_i;
    chosen_nxt = chosen_i;
    cused_nxt  = cused_i;
    dcost_nxt  = dcost_i;
    cap_nxt    = cap_r;
    cost_nxt   = cost_r;
    used_nxt   = used_r;
    mark_nxt   = mark_r;
    sum        = {1'b0, used_r} + {1'b0, size_i};
    fits       = (sum <= {1'b0, cap_r});
    hit_idx    = (int'(idx_i) == CELL_ID);
    in_range   = (int'(bins_in_use_i) > CELL_ID);
    if (ctl_i.valid) begin
      unique case (ctl_i.op)
        OP_LOAD: begin
          if (hit_idx) begin
            // reload empties the bin; old cost leaves the total
            ctl_nxt.dec = mark_r;
            dcost_nxt   = cost_r;
            used_nxt    = '0;
            mark_nxt    = 1'b0;
            cap_nxt     = cap_i;
            cost_nxt    = cost_i;
          end
        end
        OP_PLACE: begin
          if (!ctl_i.found && in_range && fits) begin
            used_nxt      = sum[VALUE_BITS-1:0];
            ctl_nxt.found = 1'b1;
            chosen_nxt    = BIN_W'(CELL_ID);
            cused_nxt     = sum[VALUE_BITS-1:0];
            if (!mark_r) begin
              mark_nxt    = 1'b1;
              ctl_nxt.inc = 1'b1;
              dcost_nxt   = cost_r;
            end
          end
        end
        OP_CLEAR: begin
          used_nxt = '0;
          mark_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '0;
      cap_r  <= '0;
      cost_r <= '0;
      used_r <= '0;
      mark_r <= 1'b0;
    end else if (adv_i) begin
      ctl_r  <= ctl_nxt;
      cap_r  <= cap_nxt;
      cost_r <= cost_nxt;
      used_r <= used_nxt;
      mark_r <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      idx_r    <= idx_i;
      tcap_r   <= cap_i;
      tcost_r  <= cost_i;
      size_r   <= size_i;
      chosen_r <= chosen_nxt;
      cused_r  <= cused_nxt;
      dcost_r  <= dcost_nxt;
    end
  end

  assign ctl_o    = ctl_r;
  assign idx_o    = idx_r;
  assign cap_o    = tcap_r;
  assign cost_o   = tcost_r;
  assign size_o   = size_r;
  assign chosen_o = chosen_r;
  assign cused_o  = cused_r;
  assign dcost_o  = dcost_r;

endmodule

// ----- rtl/ffba_tally.sv -----
// ----------------------------------------------------------------------------
// ffba_tally
// End of the cell row: keeps the non-empty count and total cost, holds the
// result word and generates the row-wide advance.
// ----------------------------------------------------------------------------
module ffba_tally
  import ffba_pkg::*;
#(
  parameter int VALUE_BITS = FFBA_VALUE_BITS,
  parameter int BIN_W      = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tok_ctl_t              ctl_i,
  input  logic [BIN_W-1:0]      chosen_i,
  input  logic [VALUE_BITS-1:0] cused_i,
  input  logic [VALUE_BITS-1:0] dcost_i,
  input  logic                  out_ready_i,
  output logic                  adv_o,
  output logic                  out_valid_o,
  output logic                  out_placed_o,
  output logic [IDX_W-1:0]      out_chosen_bin_o,
  output logic [FIELD_W-1:0]    out_chosen_used_o,
  output logic [CNT_W-1:0]      out_bins_nonempty_o,
  output logic [COST_W-1:0]     out_total_cost_o
);

  logic                out_valid_r;
  logic                placed_r;
  logic [IDX_W-1:0]    chosen_r;
  logic [FIELD_W-1:0]  cused_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [COST_W-1:0]   tcost_r, tcost_nxt;
  logic [COST_W-1:0]   delta;

  assign adv_o = !out_valid_r || out_ready_i;

  always_comb begin
    cnt_nxt   = cnt_r;
    tcost_nxt = tcost_r;
    delta     = COST_W'(dcost_i);
    if (ctl_i.valid) begin
      priority if (ctl_i.op == OP_CLEAR) begin
        cnt_nxt   = '0;
        tcost_nxt = '0;
      end else if (ctl_i.inc) begin
        cnt_nxt   = cnt_r + 1'b1;
        tcost_nxt = tcost_r + delta;
      end else if (ctl_i.dec) begin
        cnt_nxt   = cnt_r - 1'b1;
        tcost_nxt = tcost_r - delta;
      end else begin
        cnt_nxt   = cnt_r;
        tcost_nxt = tcost_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      tcost_r     <= '0;
    end else if (adv_o) begin
      out_valid_r <= ctl_i.valid;
      cnt_r       <= cnt_nxt;
      tcost_r     <= tcost_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      placed_r <= ctl_i.found;
      chosen_r <= IDX_W'(chosen_i);
      cused_r  <= FIELD_W'(cused_i);
    end
  end

  assign out_valid_o         = out_valid_r;
  assign out_placed_o        = placed_r;
  assign out_chosen_bin_o    = chosen_r;
  assign out_chosen_used_o   = cused_r;
  assign out_bins_nonempty_o = cnt_r;
  assign out_total_cost_o    = tcost_r;

endmodule

// ----- rtl/first_fit_bin_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// first_fit_bin_allocator_unit
// First-fit placement into costed bins of variable capacity.
// ----------------------------------------------------------------------------
// Request words enter on in_* (valid/ready): load a bin's capacity and cost,
// place an item, or clear all usage. Every request yields one result word on
// out_* with the placement outcome, the non-empty bin count and total cost.
// cfg_* writes bins_in_use, the number of bins searched from bin 0; write it
// only while no request is in flight.
// Each bin lives in one cell of a row of NUM_BINS cells. A request word moves
// one cell per cycle while the row advances, then into the result register.
// Words follow each other down the row, one request accepted per cycle unless
// the row holds. The row and the result register advance together: while
// a result waits on a low out_ready the whole row holds and in_ready drops.
// Reset empties all bins, zeroes capacities, costs and counters and sets
// bins_in_use to 16; no request is in flight afterwards.
// ----------------------------------------------------------------------------
module first_fit_bin_allocator_unit
  import ffba_pkg::*;
#(
  parameter int NUM_BINS   = FFBA_NUM_BINS,
  parameter int VALUE_BITS = FFBA_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [IDX_W-1:0]   in_bin_index,
  input  logic [FIELD_W-1:0] in_bin_capacity_in,
  input  logic [FIELD_W-1:0] in_bin_cost_in,
  input  logic [FIELD_W-1:0] in_item_size,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_placed,
  output logic [IDX_W-1:0]   out_chosen_bin,
  output logic [FIELD_W-1:0] out_chosen_used,
  output logic [CNT_W-1:0]   out_bins_nonempty,
  output logic [COST_W-1:0]  out_total_cost,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CNT_W-1:0]   cfg_bins_in_use
);

  localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  logic [CNT_W-1:0] bins_in_use_r;
  logic             adv;

  tok_ctl_t              ctl_s    [NUM_BINS+1];
  logic [IDX_W-1:0]      idx_s    [NUM_BINS+1];
  logic [VALUE_BITS-1:0] cap_s    [NUM_BINS+1];
  logic [VALUE_BITS-1:0] cost_s   [NUM_BINS+1];
  logic [VALUE_BITS-1:0] size_s   [NUM_BINS+1];
  logic [BIN_W-1:0]      chosen_s [NUM_BINS+1];
  logic [VALUE_BITS-1:0] cused_s  [NUM_BINS+1];
  logic [VALUE_BITS-1:0] dcost_s  [NUM_BINS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_in_use_r <= BINS_IN_USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      bins_in_use_r <= cfg_bins_in_use;
    end
  end

  assign in_ready = adv;

  // entry word
  assign ctl_s[0]    = '{valid: in_valid, op: op_t'(in_operation), found: 1'b0,
                         inc: 1'b0, dec: 1'b0};
  assign idx_s[0]    = in_bin_index;
  assign cap_s[0]    = VALUE_BITS'(in_bin_capacity_in);
  assign cost_s[0]   = VALUE_BITS'(in_bin_cost_in);
  assign size_s[0]   = VALUE_BITS'(in_item_size);
  assign chosen_s[0] = '0;
  assign cused_s[0]  = '0;
  assign dcost_s[0]  = '0;

  for (genvar k = 0; k < NUM_BINS; k++) begin : g_cell
    ffba_cell #(
      .VALUE_BITS (VALUE_BITS),
      .BIN_W      (BIN_W),
      .CELL_ID    (k)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .adv_i         (adv),
      .bins_in_use_i (bins_in_use_r),
      .ctl_i         (ctl_s[k]),
      .idx_i         (idx_s[k]),
      .cap_i         (cap_s[k]),
      .cost_i        (cost_s[k]),
      .size_i        (size_s[k]),
      .chosen_i      (chosen_s[k]),
      .cused_i       (cused_s[k]),
      .dcost_i       (dcost_s[k]),
      .ctl_o         (ctl_s[k+1]),
      .idx_o         (idx_s[k+1]),
      .cap_o         (cap_s[k+1]),
      .cost_o        (cost_s[k+1]),
      .size_o        (size_s[k+1]),
      .chosen_o      (chosen_s[k+1]),
      .cused_o       (cused_s[k+1]),
      .dcost_o       (dcost_s[k+1])
    );
  end

  ffba_tally #(
    .VALUE_BITS (VALUE_BITS),
    .BIN_W      (BIN_W)
  ) u_tally (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl_i               (ctl_s[NUM_BINS]),
    .chosen_i            (chosen_s[NUM_BINS]),
    .cused_i             (cused_s[NUM_BINS]),
    .dcost_i             (dcost_s[NUM_BINS]),
    .out_ready_i         (out_ready),
    .adv_o               (adv),
    .out_valid_o         (out_valid),
    .out_placed_o        (out_placed),
    .out_chosen_bin_o    (out_chosen_bin),
    .out_chosen_used_o   (out_chosen_used),
    .out_bins_nonempty_o (out_bins_nonempty),
    .out_total_cost_o    (out_total_cost)
  );

endmodule

// ----- rtl/ffba_checker.sv -----
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks for the first-fit bin allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffba_checker
  import ffba_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_placed,
  input logic [IDX_W-1:0]   out_chosen_bin,
  input logic [FIELD_W-1:0] out_chosen_used,
  input logic [CNT_W-1:0]   out_bins_nonempty,
  input logic [COST_W-1:0]  out_total_cost
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_placed) &&
      $stable(out_chosen_bin) && $stable(out_chosen_used) &&
      $stable(out_bins_nonempty) && $stable(out_total_cost))
    else $error("result word changed while stalled");

  // input side only stalls while a result is stuck
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stall");

  a_not_placed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_placed |-> out_chosen_bin == '0 && out_chosen_used == '0)
    else $error("unplaced result carries a bin or usage");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

endmodule

bind first_fit_bin_allocator_unit ffba_checker u_ffba_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_placed        (out_placed),
  .out_chosen_bin    (out_chosen_bin),
  .out_chosen_used   (out_chosen_used),
  .out_bins_nonempty (out_bins_nonempty),
  .out_total_cost    (out_total_cost)
);

// ----- tb/sv/ffba_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffba_scoreboard
// Watches the request, result and config channels of the first-fit bin
// allocator, keeps its own copy of the bin tables and compares every result
// word against the outcome predicted when its request was accepted.
// ----------------------------------------------------------------------------
module ffba_scoreboard
  import ffba_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [IDX_W-1:0]   in_bin_index,
  input  logic [FIELD_W-1:0] in_bin_capacity_in,
  input  logic [FIELD_W-1:0] in_bin_cost_in,
  input  logic [FIELD_W-1:0] in_item_size,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_placed,
  input  logic [IDX_W-1:0]   out_chosen_bin,
  input  logic [FIELD_W-1:0] out_chosen_used,
  input  logic [CNT_W-1:0]   out_bins_nonempty,
  input  logic [COST_W-1:0]  out_total_cost,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CNT_W-1:0]   cfg_bins_in_use,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic               placed;
    logic [IDX_W-1:0]   bin;
    logic [FIELD_W-1:0] used;
    logic [CNT_W-1:0]   nonempty;
    logic [COST_W-1:0]  cost;
  } outcome_t;

  logic [FIELD_W-1:0] bin_cap  [FFBA_NUM_BINS];
  logic [FIELD_W-1:0] bin_cost [FFBA_NUM_BINS];
  logic [FIELD_W-1:0] bin_fill [FFBA_NUM_BINS];
  logic               bin_busy [FFBA_NUM_BINS];
  logic [COST_W-1:0]  cost_sum;
  logic [CNT_W-1:0]   busy_count;
  logic [CNT_W-1:0]   search_span;

  outcome_t outcome_q[$];
  int       mismatches = 0;

  assign fail_count = mismatches;

  task automatic reset_tables();
    for (int b = 0; b < FFBA_NUM_BINS; b++) begin
      bin_cap[b]  = '0;
      bin_cost[b] = '0;
      bin_fill[b] = '0;
      bin_busy[b] = 1'b0;
    end
    cost_sum    = '0;
    busy_count  = '0;
    search_span = BINS_IN_USE_RST;
  endtask

  // Applies one request to the shadow tables and queues the outcome.
  task automatic allocate_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                  input logic [FIELD_W-1:0] cap, input logic [FIELD_W-1:0] cost,
                                  input logic [FIELD_W-1:0] size);
    outcome_t         res;
    int               span;
    logic [FIELD_W:0] sum;
    res = '0;
    case (op)
      OP_LOAD: begin
        // reloading a non-empty bin drops its old cost first
        if (bin_busy[idx]) begin
          bin_busy[idx] = 1'b0;
          cost_sum      = cost_sum - COST_W'(bin_cost[idx]);
          busy_count    = busy_count - 1'b1;
        end
        bin_fill[idx] = '0;
        bin_cap[idx]  = cap;
        bin_cost[idx] = cost;
      end
      OP_PLACE: begin
        span = (search_span > FFBA_NUM_BINS) ? FFBA_NUM_BINS : int'(search_span);
        for (int b = 0; b < span; b++) begin
          sum = {1'b0, bin_fill[b]} + {1'b0, size};
          if (!res.placed && sum <= {1'b0, bin_cap[b]}) begin
            bin_fill[b] = sum[FIELD_W-1:0];
            if (!bin_busy[b]) begin
              bin_busy[b] = 1'b1;
              cost_sum    = cost_sum + COST_W'(bin_cost[b]);
              busy_count  = busy_count + 1'b1;
            end
            res.placed = 1'b1;
            res.bin    = IDX_W'(b);
            res.used   = bin_fill[b];
          end
        end
      end
      OP_CLEAR: begin
        for (int b = 0; b < FFBA_NUM_BINS; b++) begin
          bin_fill[b] = '0;
          bin_busy[b] = 1'b0;
        end
        cost_sum   = '0;
        busy_count = '0;
      end
      default: ;
    endcase
    res.nonempty = busy_count;
    res.cost     = cost_sum;
    outcome_q.insert(outcome_q.size(), res);
  endtask

  task automatic check_result(input outcome_t got);
    outcome_t want;
    if (outcome_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result word placed=%0d bin=%0d used=%0d nonempty=%0d cost=%0d",
                 $time, got.placed, got.bin, got.used, got.nonempty, got.cost);
    end else begin
      want = outcome_q.pop_front();
      if (got.placed !== want.placed || got.bin !== want.bin || got.used !== want.used ||
          got.nonempty !== want.nonempty || got.cost !== want.cost) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: result mismatch exp placed=%0d bin=%0d used=%0d nonempty=%0d ",
                    "cost=%0d / act placed=%0d bin=%0d used=%0d nonempty=%0d cost=%0d"},
                   $time, want.placed, want.bin, want.used, want.nonempty, want.cost,
                   got.placed, got.bin, got.used, got.nonempty, got.cost);
      end
    end
  endtask

  initial reset_tables();

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_tables();
      outcome_q.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready)
        check_result({out_placed, out_chosen_bin, out_chosen_used, out_bins_nonempty,
                      out_total_cost});
      if (cfg_valid && cfg_ready)
        search_span = cfg_bins_in_use;
      if (in_valid && in_ready)
        allocate_request(in_operation, in_bin_index, in_bin_capacity_in, in_bin_cost_in,
                         in_item_size);
      pending <= outcome_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives request, result and config traffic into the first-fit bin allocator
// with random stalls on both sides and gives the final verdict from the
// checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_top
  import ffba_pkg::*;
;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 60;
  localparam int DRAIN_CYCLES   = 40;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [OP_W-1:0]    in_operation;
  logic [IDX_W-1:0]   in_bin_index;
  logic [FIELD_W-1:0] in_bin_capacity_in;
  logic [FIELD_W-1:0] in_bin_cost_in;
  logic [FIELD_W-1:0] in_item_size;
  logic               out_valid;
  logic               out_ready;
  logic               out_placed;
  logic [IDX_W-1:0]   out_chosen_bin;
  logic [FIELD_W-1:0] out_chosen_used;
  logic [CNT_W-1:0]   out_bins_nonempty;
  logic [COST_W-1:0]  out_total_cost;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CNT_W-1:0]   cfg_bins_in_use;

  int fail_count;
  int pending;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  first_fit_bin_allocator_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_bin_index       (in_bin_index),
    .in_bin_capacity_in (in_bin_capacity_in),
    .in_bin_cost_in     (in_bin_cost_in),
    .in_item_size       (in_item_size),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_placed         (out_placed),
    .out_chosen_bin     (out_chosen_bin),
    .out_chosen_used    (out_chosen_used),
    .out_bins_nonempty  (out_bins_nonempty),
    .out_total_cost     (out_total_cost),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_bins_in_use    (cfg_bins_in_use)
  );

  ffba_scoreboard u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_bin_index       (in_bin_index),
    .in_bin_capacity_in (in_bin_capacity_in),
    .in_bin_cost_in     (in_bin_cost_in),
    .in_item_size       (in_item_size),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_placed         (out_placed),
    .out_chosen_bin     (out_chosen_bin),
    .out_chosen_used    (out_chosen_used),
    .out_bins_nonempty  (out_bins_nonempty),
    .out_total_cost     (out_total_cost),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_bins_in_use    (cfg_bins_in_use),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [FIELD_W-1:0] rand_capacity();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return FIELD_W'($urandom);
      default: return FIELD_W'($urandom_range(100, 20000));
    endcase
  endfunction

  // Presents one request word and returns at the edge that accepts it.
  task automatic offer(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                       input logic [FIELD_W-1:0] cap, input logic [FIELD_W-1:0] cost,
                       input logic [FIELD_W-1:0] size);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= op;
    in_bin_index       <= idx;
    in_bin_capacity_in <= cap;
    in_bin_cost_in     <= cost;
    in_item_size       <= size;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic offer_random();
    int                 pick;
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] size;
    pick = $urandom_range(0, 99);
    if (pick < 15)      op = OP_LOAD;
    else if (pick < 90) op = OP_PLACE;
    else if (pick < 95) op = OP_CLEAR;
    else                op = OP_UNUSED;
    case ($urandom_range(0, 9))
      0:       size = '0;
      1:       size = FIELD_W'($urandom);
      default: size = FIELD_W'($urandom_range(1, 3000));
    endcase
    offer(op, IDX_W'($urandom), rand_capacity(), FIELD_W'($urandom), size);
  endtask

  // Waits for every result to drain, then writes the search span.
  task automatic write_span(input logic [CNT_W-1:0] span);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    cfg_valid       <= 1'b1;
    cfg_bins_in_use <= span;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] span, input bit with_hold);
    write_span(span);
    for (int b = 0; b < FFBA_NUM_BINS; b++)
      offer(OP_LOAD, IDX_W'(b), rand_capacity(), FIELD_W'($urandom), FIELD_W'($urandom));
    if (with_hold)
      hold_req = 1'b1;
    repeat (220) offer_random();
  endtask

  // result side: random stall bursts, plus one long hold on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_operation       <= OP_LOAD;
    in_bin_index       <= '0;
    in_bin_capacity_in <= '0;
    in_bin_cost_in     <= '0;
    in_item_size       <= '0;
    cfg_valid          <= 1'b0;
    cfg_bins_in_use    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero-size item fits a zero-capacity bin and still marks it
    offer(OP_PLACE, 4'd0, 16'd0, 16'd0, 16'd0);
    offer(OP_PLACE, 4'd0, 16'd0, 16'd0, 16'd1);
    // reload of the non-empty bin 0 at full scale
    offer(OP_LOAD, 4'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    offer(OP_LOAD, 4'd15, 16'd100, 16'd1, 16'd0);
    offer(OP_LOAD, 4'd7, 16'd0, 16'h5555, 16'd0);
    offer(OP_PLACE, 4'd0, 16'd0, 16'd0, 16'hFFFF);
    offer(OP_PLACE, 4'd0, 16'd0, 16'd0, 16'd1);
    offer(OP_PLACE, 4'd0, 16'd0, 16'd0, 16'd0);
    // nothing fits, then 99 fills bin 15 to capacity, then nothing fits again
    offer(OP_PLACE, 4'd0, 16'd0, 16'd0, 16'hFFFF);
    offer(OP_PLACE, 4'd0, 16'd0, 16'd0, 16'd99);
    offer(OP_PLACE, 4'd0, 16'd0, 16'd0, 16'd1);
    offer(OP_LOAD, 4'd0, 16'd10, 16'h8000, 16'hFFFF);
    offer(OP_PLACE, 4'hF, 16'hFFFF, 16'hFFFF, 16'd10);
    offer(OP_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer(OP_CLEAR, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer(OP_PLACE, 4'd0, 16'd0, 16'd0, 16'd0);
    offer(OP_LOAD, 4'hF, 16'hFFFF, 16'hFFFF, 16'd0);
    offer(OP_PLACE, 4'd0, 16'd0, 16'd0, 16'h8000);
    offer(OP_CLEAR, 4'd0, 16'd0, 16'd0, 16'd0);

    run_phase(5'd16, 1'b0);
    run_phase(5'd31, 1'b1);   // above the bin count: all bins searched
    run_phase(5'd0, 1'b0);    // no bin searched
    run_phase(5'd1, 1'b0);
    run_phase(5'd17, 1'b0);
    run_phase(CNT_W'($urandom_range(2, 15)), 1'b0);
    idle_on = 1'b0;
    run_phase(5'd16, 1'b0);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
